/* rtl/core/tspa_pkg.sv */
// ============================================================================
// tspa_pkg: shared types and codes of the tagged slot pool allocator
// Request codes, slot kinds, result status codes, sequencer states and the
// layout of one stored slot entry.
// ============================================================================
package tspa_pkg;

    // Request codes carried on req_type.
    localparam logic [2:0] REQ_ALLOC      = 3'd0;
    localparam logic [2:0] REQ_FREE_INDEX = 3'd1;
    localparam logic [2:0] REQ_FREE_OWNER = 3'd2;
    localparam logic [2:0] REQ_CLEAR      = 3'd3;
    localparam logic [2:0] REQ_READ       = 3'd4;
    localparam logic [2:0] REQ_FIND_NEXT  = 3'd5;

    // Slot kinds.
    localparam logic [1:0] KIND_EMPTY  = 2'd0;
    localparam logic [1:0] KIND_LOCAL  = 2'd1;
    localparam logic [1:0] KIND_REMOTE = 2'd2;
    localparam logic [1:0] KIND_BOT    = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;
    localparam logic [1:0] STATUS_NONE  = 2'd3;

    // Capacity after reset.
    localparam int RESET_CAPACITY = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // What the slot scanner does with each slot it visits.
    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE_INDEX,
        OP_FREE_OWNER,
        OP_READ,
        OP_FIND_NEXT,
        OP_RECOUNT
    } scan_op_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        team;
        logic signed [7:0] owner;
        logic [7:0]        local_number;
    } slot_entry_t;

endpackage

/* rtl/core/tspa_ram.sv */
// ============================================================================
// tspa_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module tspa_ram #(
    parameter int WIDTH  = 26,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

/* rtl/core/tagged_slot_pool_allocator_core.sv */
// ============================================================================
// tagged_slot_pool_allocator_core: first-fit allocator over a table of slots
// Keeps a table of typed slots (kind, team, owner, local number) and serves
// allocate, free, free-by-owner, clear, read and find-next requests.
// ============================================================================
// The block serves one request at a time. A single slot scanner walks the
// table one slot per cycle, reading each slot from the RAM in the cycle before
// its compare. Some requests walk the whole table in use without stopping
// (allocate into a full table, free owner, find next from the start that finds
// nothing); the others stop at the first matching slot. A request on one slot
// (read, free index) reads and compares just that slot, occupied or empty.
// Clear, an allocate of kind empty, an unused request type and an out-of-range
// index go straight to the result without a scan. A result that cannot enter
// the output register because the previous one is still waiting holds the
// block until that wait ends. The block is ready again on the edge at which
// the result enters the output register, so a new request is taken in the
// next cycle at the earliest. A write to the capacity register clears every
// slot at or above the new capacity at once and then recounts the slots below
// it, which keeps the block busy, and no request is taken meanwhile. The
// finished result sits in an output register, so the next request is accepted
// while it still waits to be taken. Occupancy is one flip-flop per slot; the
// slot contents live in a RAM that needs no clearing, since an empty slot's
// contents are never reported.
module tagged_slot_pool_allocator_core #(
    parameter int SLOTS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [5:0]        cfg_capacity_in_use,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_req_type,
    input  logic signed [5:0] s_slot_index,
    input  logic [1:0]        s_entry_kind,
    input  logic              s_match_any_kind,
    input  logic [7:0]        s_team_in,
    input  logic signed [7:0] s_owner_in,
    input  logic [7:0]        s_local_number_in,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [4:0]        m_slot_out,
    output logic [1:0]        m_kind_out,
    output logic [7:0]        m_team_out,
    output logic signed [7:0] m_owner_out,
    output logic [7:0]        m_local_number_out,
    output logic [5:0]        m_active_count,
    output logic [5:0]        m_bot_count,
    output logic [5:0]        m_local_count,
    output logic [5:0]        m_remote_count
);

    import tspa_pkg::*;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CAP_W   = $clog2(SLOTS + 1);
    // Compare width: wide enough for the capacity field and for SLOTS itself.
    localparam int CW      = (CAP_W > 6) ? CAP_W : 6;
    localparam int ENTRY_W = $bits(slot_entry_t);
    localparam logic [CW-1:0] SLOTS_CW  = CW'(SLOTS);
    localparam logic [CW-1:0] RESET_EFF =
        (RESET_CAPACITY > SLOTS) ? CW'(SLOTS) : CW'(RESET_CAPACITY);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    scan_op_t          op_reg, op_next;
    logic [SLOTS-1:0]  occ_reg, occ_next;
    logic [CW-1:0]     eff_cap_reg, eff_cap_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     end_reg, end_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic              hit_reg, hit_next;
    logic [CAP_W-1:0]  cnt_bot_reg, cnt_bot_next;
    logic [CAP_W-1:0]  cnt_local_reg, cnt_local_next;
    logic [CAP_W-1:0]  cnt_remote_reg, cnt_remote_next;

    // Request fields held for the duration of a scan.
    logic [1:0]        req_kind_reg, req_kind_next;
    logic              req_any_reg, req_any_next;
    logic [7:0]        req_team_reg, req_team_next;
    logic signed [7:0] req_owner_reg, req_owner_next;
    logic [7:0]        req_local_reg, req_local_next;

    // Result being built, then the output register.
    logic [1:0]        res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_slot_reg, res_slot_next;
    slot_entry_t       res_entry_reg, res_entry_next;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [4:0]        out_slot_reg, out_slot_next;
    slot_entry_t       out_entry_reg, out_entry_next;
    logic [5:0]        out_active_reg, out_active_next;
    logic [5:0]        out_bot_reg, out_bot_next;
    logic [5:0]        out_local_reg, out_local_next;
    logic [5:0]        out_remote_reg, out_remote_next;

    // ------------------------------------------------------------------
    // Slot RAM
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    slot_entry_t        ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    slot_entry_t        rd_entry;

    tspa_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (SLOTS),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = slot_entry_t'(ram_rdata);

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic [CW-1:0]    idx_ext;
    logic             idx_neg;
    logic             in_range;
    logic [CW-1:0]    cap_in_wide;
    logic [CW-1:0]    cap_new;
    logic [CAP_W-1:0] active_sum;

    assign idx_neg     = s_slot_index[5];
    assign idx_ext     = CW'(s_slot_index[4:0]);
    assign in_range    = !idx_neg && (idx_ext < eff_cap_reg);
    // Capacities beyond the table size saturate to the table size.
    assign cap_in_wide = CW'(cfg_capacity_in_use);
    assign cap_new     = (cap_in_wide > SLOTS_CW) ? SLOTS_CW : cap_in_wide;
    assign active_sum  = cnt_bot_reg + cnt_local_reg + cnt_remote_reg;

    // ------------------------------------------------------------------
    // Slot scanner: one compare per cycle on the slot read last cycle.
    // ------------------------------------------------------------------
    logic pend_occ;
    logic scan_match;
    logic scan_hit;
    logic scan_stops;
    logic issue_ok;
    logic scan_finished;

    assign pend_occ = occ_reg[pidx_reg];

    always_comb begin
        unique case (op_reg)
            OP_ALLOC:      scan_match = !pend_occ;
            OP_FREE_INDEX: scan_match = pend_occ;
            OP_READ:       scan_match = pend_occ;
            OP_RECOUNT:    scan_match = pend_occ;
            OP_FREE_OWNER: scan_match = pend_occ && (rd_entry.owner == req_owner_reg);
            OP_FIND_NEXT:  scan_match = pend_occ && (req_any_reg ||
                               (req_kind_reg != KIND_EMPTY && rd_entry.kind == req_kind_reg));
            default:       scan_match = 1'b0;
        endcase
    end

    // Free owner and recount visit every slot in their range; the rest stop at the first hit.
    assign scan_stops    = (op_reg != OP_FREE_OWNER) && (op_reg != OP_RECOUNT);
    assign scan_hit      = pend_reg && scan_match;
    assign issue_ok      = ptr_reg < end_reg;
    assign scan_finished = !pend_reg && !issue_ok;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    state_next = ST_SCAN;
                end else if (s_valid) begin
                    unique case (s_req_type)
                        REQ_ALLOC:      state_next = (s_entry_kind != KIND_EMPTY) ? ST_SCAN
                                                                                   : ST_DONE;
                        REQ_FREE_INDEX: state_next = in_range ? ST_SCAN : ST_DONE;
                        REQ_READ:       state_next = in_range ? ST_SCAN : ST_DONE;
                        REQ_FREE_OWNER: state_next = ST_SCAN;
                        REQ_FIND_NEXT:  state_next = ST_SCAN;
                        default:        state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_hit && scan_stops) begin
                    state_next = ST_DONE;
                end else if (scan_finished) begin
                    state_next = (op_reg == OP_RECOUNT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        op_next         = op_reg;
        occ_next        = occ_reg;
        eff_cap_next    = eff_cap_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        hit_next        = hit_reg;
        cnt_bot_next    = cnt_bot_reg;
        cnt_local_next  = cnt_local_reg;
        cnt_remote_next = cnt_remote_reg;
        req_kind_next   = req_kind_reg;
        req_any_next    = req_any_reg;
        req_team_next   = req_team_reg;
        req_owner_next  = req_owner_reg;
        req_local_next  = req_local_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_entry_next  = res_entry_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_entry_next  = out_entry_reg;
        out_active_next = out_active_reg;
        out_bot_next    = out_bot_reg;
        out_local_next  = out_local_reg;
        out_remote_next = out_remote_reg;

        ram_we    = 1'b0;
        ram_waddr = pidx_reg;
        ram_raddr = ptr_reg[IDX_W-1:0];
        ram_wdata = '{kind: req_kind_reg, team: req_team_reg,
                      owner: req_owner_reg, local_number: req_local_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    // New capacity: drop everything at or above it, then recount below it.
                    eff_cap_next = cap_new;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (CW'(i) >= cap_new) begin
                            occ_next[i] = 1'b0;
                        end
                    end
                    cnt_bot_next    = '0;
                    cnt_local_next  = '0;
                    cnt_remote_next = '0;
                    op_next         = OP_RECOUNT;
                    ptr_next        = '0;
                    end_next        = cap_new;
                    pend_next       = 1'b0;
                end else if (s_valid) begin
                    req_kind_next   = s_entry_kind;
                    req_any_next    = s_match_any_kind;
                    req_team_next   = s_team_in;
                    req_owner_next  = s_owner_in;
                    req_local_next  = s_local_number_in;
                    res_status_next = STATUS_NONE;
                    res_slot_next   = '0;
                    res_entry_next  = '0;
                    hit_next        = 1'b0;
                    pend_next       = 1'b0;
                    ptr_next        = '0;
                    end_next        = eff_cap_reg;
                    unique case (s_req_type)
                        REQ_ALLOC: begin
                            op_next = OP_ALLOC;
                        end
                        REQ_FREE_INDEX: begin
                            op_next = OP_FREE_INDEX;
                            if (!in_range) begin
                                res_status_next = STATUS_RANGE;
                            end
                            ptr_next = idx_ext;
                            end_next = idx_ext + CW'(1);
                        end
                        REQ_READ: begin
                            op_next = OP_READ;
                            if (!in_range) begin
                                res_status_next = STATUS_RANGE;
                            end
                            ptr_next = idx_ext;
                            end_next = idx_ext + CW'(1);
                        end
                        REQ_FREE_OWNER: begin
                            op_next = OP_FREE_OWNER;
                        end
                        REQ_CLEAR: begin
                            occ_next        = '0;
                            cnt_bot_next    = '0;
                            cnt_local_next  = '0;
                            cnt_remote_next = '0;
                            res_status_next = STATUS_OK;
                        end
                        REQ_FIND_NEXT: begin
                            op_next  = OP_FIND_NEXT;
                            // A negative start index searches from slot zero.
                            ptr_next = idx_neg ? '0 : (idx_ext + CW'(1));
                        end
                        default: begin
                            res_status_next = STATUS_NONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // A stopping hit ends the scan, so no further slot is read.
                if (issue_ok && !(scan_hit && scan_stops)) begin
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[IDX_W-1:0];
                end else begin
                    pend_next = 1'b0;
                end

                if (scan_hit) begin
                    unique case (op_reg)
                        OP_ALLOC: begin
                            ram_we              = 1'b1;
                            occ_next[pidx_reg]  = 1'b1;
                            res_status_next     = STATUS_OK;
                            res_slot_next       = pidx_reg;
                            res_entry_next      = ram_wdata;
                            unique case (req_kind_reg)
                                KIND_BOT:    cnt_bot_next    = cnt_bot_reg + CAP_W'(1);
                                KIND_LOCAL:  cnt_local_next  = cnt_local_reg + CAP_W'(1);
                                KIND_REMOTE: cnt_remote_next = cnt_remote_reg + CAP_W'(1);
                                default: ;
                            endcase
                        end
                        OP_FREE_INDEX, OP_FREE_OWNER: begin
                            occ_next[pidx_reg] = 1'b0;
                            unique case (rd_entry.kind)
                                KIND_BOT:    cnt_bot_next    = cnt_bot_reg - CAP_W'(1);
                                KIND_LOCAL:  cnt_local_next  = cnt_local_reg - CAP_W'(1);
                                KIND_REMOTE: cnt_remote_next = cnt_remote_reg - CAP_W'(1);
                                default: ;
                            endcase
                            if (op_reg == OP_FREE_INDEX) begin
                                res_status_next = STATUS_OK;
                                res_slot_next   = pidx_reg;
                                res_entry_next  = rd_entry;
                            end else begin
                                hit_next = 1'b1;
                            end
                        end
                        OP_READ, OP_FIND_NEXT: begin
                            res_status_next = STATUS_OK;
                            res_slot_next   = pidx_reg;
                            res_entry_next  = rd_entry;
                        end
                        OP_RECOUNT: begin
                            unique case (rd_entry.kind)
                                KIND_BOT:    cnt_bot_next    = cnt_bot_reg + CAP_W'(1);
                                KIND_LOCAL:  cnt_local_next  = cnt_local_reg + CAP_W'(1);
                                KIND_REMOTE: cnt_remote_next = cnt_remote_reg + CAP_W'(1);
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end else if (scan_finished) begin
                    // Walked the whole range without a stopping hit.
                    if (op_reg == OP_ALLOC) begin
                        res_status_next = STATUS_FULL;
                    end else if (op_reg == OP_FREE_OWNER) begin
                        res_status_next = hit_reg ? STATUS_OK : STATUS_NONE;
                    end
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = 5'(res_slot_reg);
                    out_entry_next  = res_entry_reg;
                    out_active_next = 6'(active_sum);
                    out_bot_next    = 6'(cnt_bot_reg);
                    out_local_next  = 6'(cnt_local_reg);
                    out_remote_next = 6'(cnt_remote_reg);
                end
            end

            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Register updates
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_ALLOC;
            occ_reg        <= '0;
            eff_cap_reg    <= RESET_EFF;
            ptr_reg        <= '0;
            end_reg        <= '0;
            pend_reg       <= 1'b0;
            pidx_reg       <= '0;
            hit_reg        <= 1'b0;
            cnt_bot_reg    <= '0;
            cnt_local_reg  <= '0;
            cnt_remote_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            occ_reg        <= occ_next;
            eff_cap_reg    <= eff_cap_next;
            ptr_reg        <= ptr_next;
            end_reg        <= end_next;
            pend_reg       <= pend_next;
            pidx_reg       <= pidx_next;
            hit_reg        <= hit_next;
            cnt_bot_reg    <= cnt_bot_next;
            cnt_local_reg  <= cnt_local_next;
            cnt_remote_reg <= cnt_remote_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_kind_reg   <= req_kind_next;
        req_any_reg    <= req_any_next;
        req_team_reg   <= req_team_next;
        req_owner_reg  <= req_owner_next;
        req_local_reg  <= req_local_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_entry_reg  <= res_entry_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_entry_reg  <= out_entry_next;
        out_active_reg <= out_active_next;
        out_bot_reg    <= out_bot_next;
        out_local_reg  <= out_local_next;
        out_remote_reg <= out_remote_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = out_status_reg;
    assign m_slot_out         = out_slot_reg;
    assign m_kind_out         = out_entry_reg.kind;
    assign m_team_out         = out_entry_reg.team;
    assign m_owner_out        = out_entry_reg.owner;
    assign m_local_number_out = out_entry_reg.local_number;
    assign m_active_count     = out_active_reg;
    assign m_bot_count        = out_bot_reg;
    assign m_local_count      = out_local_reg;
    assign m_remote_count     = out_remote_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Between requests the kind counters never claim more slots than are in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (CW'(active_sum) <= eff_cap_reg))
        else $error("kind counters exceed the capacity in use");

    // A configuration write and a request are never taken in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cfg_valid && cfg_ready && s_valid && s_ready))
        else $error("configuration write and request accepted together");

    // A pending slot read only exists while the scanner runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("slot read pending outside a scan");

    // Once a request is taken, the next one waits until this one completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in progress");

endmodule
